/* hdl/rv32i_instruction_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// RV32I decoder assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_UNIT_ASSERT_SVH

// Checked only while reset is low.
`define RV32ID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RV32ID_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/rv32id_pkg.sv */
// ----------------------------------------------------------------------------
// RV32I decoder package
// Opcode, format and operation codes, lookup functions and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rv32id_pkg;

  localparam int WordW = 32;
  localparam int FmtW  = 3;
  localparam int OpW   = 6;
  localparam int OutDataW = 80;

  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  localparam logic [FmtW-1:0] FMT_R = 3'd0;
  localparam logic [FmtW-1:0] FMT_I = 3'd1;
  localparam logic [FmtW-1:0] FMT_S = 3'd2;
  localparam logic [FmtW-1:0] FMT_B = 3'd3;
  localparam logic [FmtW-1:0] FMT_U = 3'd4;
  localparam logic [FmtW-1:0] FMT_J = 3'd5;
  localparam logic [FmtW-1:0] FMT_X = 3'd6;

  localparam logic [OpW-1:0] OP_ADD   = 6'd0;
  localparam logic [OpW-1:0] OP_SUB   = 6'd1;
  localparam logic [OpW-1:0] OP_SLL   = 6'd2;
  localparam logic [OpW-1:0] OP_SLT   = 6'd3;
  localparam logic [OpW-1:0] OP_SLTU  = 6'd4;
  localparam logic [OpW-1:0] OP_XOR   = 6'd5;
  localparam logic [OpW-1:0] OP_SRL   = 6'd6;
  localparam logic [OpW-1:0] OP_SRA   = 6'd7;
  localparam logic [OpW-1:0] OP_OR    = 6'd8;
  localparam logic [OpW-1:0] OP_AND   = 6'd9;
  localparam logic [OpW-1:0] OP_ADDI  = 6'd10;
  localparam logic [OpW-1:0] OP_SLLI  = 6'd11;
  localparam logic [OpW-1:0] OP_SLTI  = 6'd12;
  localparam logic [OpW-1:0] OP_SLTIU = 6'd13;
  localparam logic [OpW-1:0] OP_XORI  = 6'd14;
  localparam logic [OpW-1:0] OP_SRLI  = 6'd15;
  localparam logic [OpW-1:0] OP_SRAI  = 6'd16;
  localparam logic [OpW-1:0] OP_ORI   = 6'd17;
  localparam logic [OpW-1:0] OP_ANDI  = 6'd18;
  localparam logic [OpW-1:0] OP_LB    = 6'd19;
  localparam logic [OpW-1:0] OP_LH    = 6'd20;
  localparam logic [OpW-1:0] OP_LW    = 6'd21;
  localparam logic [OpW-1:0] OP_LBU   = 6'd22;
  localparam logic [OpW-1:0] OP_LHU   = 6'd23;
  localparam logic [OpW-1:0] OP_SB    = 6'd24;
  localparam logic [OpW-1:0] OP_SH    = 6'd25;
  localparam logic [OpW-1:0] OP_SW    = 6'd26;
  localparam logic [OpW-1:0] OP_BEQ   = 6'd27;
  localparam logic [OpW-1:0] OP_BNE   = 6'd28;
  localparam logic [OpW-1:0] OP_BLT   = 6'd29;
  localparam logic [OpW-1:0] OP_BGE   = 6'd30;
  localparam logic [OpW-1:0] OP_BLTU  = 6'd31;
  localparam logic [OpW-1:0] OP_BGEU  = 6'd32;
  localparam logic [OpW-1:0] OP_JAL   = 6'd33;
  localparam logic [OpW-1:0] OP_JALR  = 6'd34;
  localparam logic [OpW-1:0] OP_LUI   = 6'd35;
  localparam logic [OpW-1:0] OP_AUIPC = 6'd36;
  localparam logic [OpW-1:0] OP_UNKNOWN = 6'd37;

  // Classification handed from the class decoder to the rest of the block.
  typedef struct packed {
    logic [FmtW-1:0] fmt;
    logic [OpW-1:0]  op;
  } decode_t;

  function automatic logic [OpW-1:0] load_op(input logic [2:0] f3);
    logic [OpW-1:0] r;
    case (f3)
      3'd0:    r = OP_LB;
      3'd1:    r = OP_LH;
      3'd2:    r = OP_LW;
      3'd4:    r = OP_LBU;
      3'd5:    r = OP_LHU;
      default: r = OP_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [OpW-1:0] store_op(input logic [2:0] f3);
    logic [OpW-1:0] r;
    case (f3)
      3'd0:    r = OP_SB;
      3'd1:    r = OP_SH;
      3'd2:    r = OP_SW;
      default: r = OP_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic [OpW-1:0] branch_op(input logic [2:0] f3);
    logic [OpW-1:0] r;
    case (f3)
      3'd0:    r = OP_BEQ;
      3'd1:    r = OP_BNE;
      3'd4:    r = OP_BLT;
      3'd5:    r = OP_BGE;
      3'd6:    r = OP_BLTU;
      3'd7:    r = OP_BGEU;
      default: r = OP_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/rv32id_class.sv */
// ----------------------------------------------------------------------------
// RV32I format and operation classifier
// Maps opcode, funct3 and funct7 to a format class and a dense operation number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rv32id_class
  import rv32id_pkg::*;
(
  input  wire logic [WordW-1:0] word,
  output decode_t               dec
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic       alt;

  assign opc = word[6:0];
  assign f3  = word[14:12];
  // Any nonzero funct7 picks the alternate operation, not just bit 30.
  assign alt = |word[31:25];

  always_comb begin
    dec.fmt = FMT_X;
    dec.op  = OP_UNKNOWN;
    case (opc)
      OPC_REG: begin
        dec.fmt = FMT_R;
        case (f3)
          3'd0:    dec.op = alt ? OP_SUB : OP_ADD;
          3'd1:    dec.op = OP_SLL;
          3'd2:    dec.op = OP_SLT;
          3'd3:    dec.op = OP_SLTU;
          3'd4:    dec.op = OP_XOR;
          3'd5:    dec.op = alt ? OP_SRA : OP_SRL;
          3'd6:    dec.op = OP_OR;
          default: dec.op = OP_AND;
        endcase
      end
      OPC_IMM: begin
        dec.fmt = FMT_I;
        case (f3)
          3'd0:    dec.op = OP_ADDI;
          3'd1:    dec.op = OP_SLLI;
          3'd2:    dec.op = OP_SLTI;
          3'd3:    dec.op = OP_SLTIU;
          3'd4:    dec.op = OP_XORI;
          3'd5:    dec.op = alt ? OP_SRAI : OP_SRLI;
          3'd6:    dec.op = OP_ORI;
          default: dec.op = OP_ANDI;
        endcase
      end
      OPC_LOAD: begin
        dec.fmt = FMT_I;
        dec.op  = load_op(f3);
      end
      OPC_JALR: begin
        dec.fmt = FMT_I;
        dec.op  = OP_JALR;
      end
      OPC_STORE: begin
        dec.fmt = FMT_S;
        dec.op  = store_op(f3);
      end
      OPC_BRANCH: begin
        dec.fmt = FMT_B;
        dec.op  = branch_op(f3);
      end
      OPC_LUI: begin
        dec.fmt = FMT_U;
        dec.op  = OP_LUI;
      end
      OPC_AUIPC: begin
        dec.fmt = FMT_U;
        dec.op  = OP_AUIPC;
      end
      OPC_JAL: begin
        dec.fmt = FMT_J;
        dec.op  = OP_JAL;
      end
      default: begin
        dec.fmt = FMT_X;
        dec.op  = OP_UNKNOWN;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/rv32id_imm.sv */
// ----------------------------------------------------------------------------
// RV32I immediate generator
// Assembles and sign-extends the immediate of the given instruction format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rv32id_imm
  import rv32id_pkg::*;
(
  input  wire logic [WordW-1:0] word,
  input  wire logic [FmtW-1:0]  fmt,
  output logic      [WordW-1:0] imm
);

  always_comb begin
    case (fmt)
      FMT_I:   imm = {{20{word[31]}}, word[31:20]};
      FMT_S:   imm = {{20{word[31]}}, word[31:25], word[11:7]};
      FMT_B:   imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      FMT_U:   imm = {word[31:12], 12'b0};
      FMT_J:   imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      default: imm = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/rv32i_instruction_decoder_unit.sv */
// ----------------------------------------------------------------------------
// RV32I instruction decoder
// Usage: instruction words enter on the s_axis channel, one 32-bit word per
// request. Each word yields exactly one decoded request on m_axis carrying
// the fixed fields, the sign-extended immediate, the format class and the
// operation number.
// The word is captured in an input register, decoded by shallow logic and
// captured in the output register, which drives m_axis. One word is accepted
// every cycle as long as the receiver keeps taking results; throughput is one
// per clock.
// When the receiver stalls, the result holds on m_axis, the input register
// keeps the next word, and s_axis_tready drops only once both are occupied.
// Synchronous reset empties both registers; no results are pending after it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rv32i_instruction_decoder_unit_assert.svh"

module rv32i_instruction_decoder_unit
  import rv32id_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [WordW-1:0]    s_axis_tdata,  // [31:0] instr_word
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [6:0] major_opcode, [11:7] dest_reg, [14:12] minor_func, [19:15] src_reg_a,
  // [24:20] src_reg_b, [31:25] upper_func, [63:32] immediate,
  // [66:64] format_class, [72:67] operation_id, [79:73] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic                in_valid;
  logic [WordW-1:0]    in_word;
  logic                out_valid;
  logic [OutDataW-1:0] out_data;
  logic [OutDataW-1:0] out_data_next;
  logic                advance;
  decode_t             dec;
  logic [WordW-1:0]    imm;

  // The decoded word moves on whenever the output register is free or being read.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  rv32id_class u_class (
    .word (in_word),
    .dec  (dec)
  );

  rv32id_imm u_imm (
    .word (in_word),
    .fmt  (dec.fmt),
    .imm  (imm)
  );

  assign out_data_next = {7'b0, dec.op, dec.fmt, imm, in_word[31:25], in_word[24:20],
                          in_word[19:15], in_word[14:12], in_word[11:7], in_word[6:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word <= s_axis_tdata;
    end
    if (advance && in_valid) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `RV32ID_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_axis_tvalid,
                        "result valid right after reset")
  `RV32ID_ASSERT(a_accept_fills_input, (s_axis_tvalid && s_axis_tready) |=> in_valid,
                 "accepted word was lost")
  `RV32ID_ASSERT(a_decode_reaches_output, (in_valid && advance) |=> m_axis_tvalid,
                 "decoded word did not reach output")
  `RV32ID_ASSERT(a_unknown_consistent,
                 (out_valid && out_data[66:64] == FMT_X) |->
                 (out_data[72:67] == OP_UNKNOWN && out_data[63:32] == '0),
                 "unknown format with known operation or nonzero immediate")

endmodule

`default_nettype wire
